FILE: rtl/sfbm_pkg.sv
// sfbm_pkg: shared types, constants and helpers for the sprite frame blitter
// no dependencies; imported by sprite_frame_blit_modulate
`default_nettype none

package sfbm_pkg;

   // screen geometry and size limits
   localparam int unsigned SCREEN_HEIGHT = 1024;
   localparam int unsigned MAX_DIM       = 4096;

   // field widths
   localparam int unsigned DIM_W   = 13;   // image size and frame step registers
   localparam int unsigned CNT_W   = 12;   // column / row counters, window offset
   localparam int unsigned NUM_W   = 16;   // frame number register
   localparam int unsigned SCALE_W = 7;
   localparam int unsigned COORD_W = 20;
   localparam int unsigned CSR_W   = 32;

   // step * number product, one remainder bit per divider cycle
   localparam int unsigned DIV_BITS = DIM_W + NUM_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS);

   // register indexes of the configuration port
   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_FRAME_STEP   = 3'd2,
      REG_FRAME_NUMBER = 3'd3,
      REG_SCALE        = 3'd4,
      REG_TINT         = 3'd5,
      REG_DEST_X       = 3'd6,
      REG_DEST_Y       = 3'd7
   } csr_index_type;

   // one rgba pixel
   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] a;
   } pixel_type;

   // size register to 1..4096
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] res;
      if (v == '0) begin
         res = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         res = DIM_W'(MAX_DIM);
      end else begin
         res = v;
      end
      return res;
   endfunction

   // px * t / 255 truncated; exact for products up to 255 * 255
   function automatic logic [7:0] modulate(input logic [7:0] px, input logic [7:0] t);
      logic [15:0] prod;
      logic [16:0] sum;
      prod = 16'(px) * 16'(t);
      sum  = 17'(prod) + 17'(prod[15:8]) + 17'd1;
      return sum[15:8];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/sprite_frame_blit_modulate.sv
// sprite_frame_blit_modulate: sprite sheet blitter with frame window and tint
// depends on sfbm_pkg (types, constants, clamp and modulate helpers)
//
// Usage:
//   req_*  : one rgba sheet pixel per request, file order, top row first.
//   rsp_*  : one scaled screen rectangle with tinted color for each pixel
//            inside the frame window; pixels outside it give nothing.
//   csr_*  : register writes; the user must write only while the block is
//            idle, which the block does not enforce. Every write restarts the
//            draw at the first pixel and recomputes the frame window: offset =
//            (step * number) mod width, found by a bit-serial remainder unit.
//            Requests stall during the product, remainder and window steps.
//   Throughput: one request per cycle unless a write, the window unit or the
//   receiver stalls it, set by the input and result registers; all per-pixel
//   work is one pass between them; rectangles are valid from the result register.
//   Receiver stall: the result register holds; the input register keeps one
//   more request, then req_stall rises until the result is taken.
//   Reset: registers return to width 1, height 1, step 0, number 0, scale 1,
//   white tint, origin 0; counters and offset cleared, window width 1, nothing pending.
`default_nettype none

module sprite_frame_blit_modulate (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // configuration
   input  wire logic                                 csr_write_en,
   input  wire sfbm_pkg::csr_index_type              csr_index,
   input  wire logic [sfbm_pkg::CSR_W-1:0]           csr_data,
   // pixel requests
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [7:0]                           req_pixel_r,
   input  wire logic [7:0]                           req_pixel_g,
   input  wire logic [7:0]                           req_pixel_b,
   input  wire logic [7:0]                           req_pixel_a,
   // rectangle responses
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [sfbm_pkg::COORD_W-1:0]       rsp_rect_x0,
   output logic signed [sfbm_pkg::COORD_W-1:0]       rsp_rect_y0,
   output logic signed [sfbm_pkg::COORD_W-1:0]       rsp_rect_x1,
   output logic signed [sfbm_pkg::COORD_W-1:0]       rsp_rect_y1,
   output logic [7:0]                                rsp_out_r,
   output logic [7:0]                                rsp_out_g,
   output logic [7:0]                                rsp_out_b,
   output logic [7:0]                                rsp_out_a,
   output logic                                      rsp_last_rect
);
   import sfbm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } win_state_type;

   // configuration registers
   logic [DIM_W-1:0]   image_width_ff, image_height_ff, frame_step_ff;
   logic [NUM_W-1:0]   frame_number_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [CSR_W-1:0]   tint_ff;
   logic [15:0]        dest_x_ff, dest_y_ff;

   // window unit
   win_state_type          state_ff;
   logic [DIV_BITS-1:0]    prod_ff;
   logic [CNT_W-1:0]       rem_ff;
   logic [DIV_CNT_W-1:0]   div_cnt_ff;
   logic [CNT_W-1:0]       window_offset_ff;
   logic [DIM_W-1:0]       window_width_ff;

   // stream counters
   logic [CNT_W-1:0]       col_ff, row_ff;

   // input register
   logic                   s1_valid_ff;
   pixel_type              s1_pixel_ff;
   logic [CNT_W-1:0]       s1_x_ff, s1_y_ff;
   logic                   s1_last_ff;

   // result register
   logic                   s2_valid_ff;

   logic [DIM_W-1:0]       img_w, img_h;
   logic [DIM_W-1:0]       trial, room;
   logic [DIM_W-1:0]       col_ext, row_ext, off_ext, win_end;
   logic                   busy, req_accept, in_window, last_in, col_wrap, row_wrap;
   logic                   s1_ready, s2_ready;
   logic [CNT_W-1:0]       x_in, y_in;
   logic [SCALE_W-1:0]     scale_eff;
   logic [COORD_W-1:0]     scale_ext, xs, ys, x0, bottom;
   logic [COORD_W-1:0]     dest_x_ext, dest_y_ext;

   assign img_w = clamp_dim(image_width_ff);
   assign img_h = clamp_dim(image_height_ff);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= DIM_W'(1);
         image_height_ff <= DIM_W'(1);
         frame_step_ff   <= '0;
         frame_number_ff <= '0;
         scale_ff        <= SCALE_W'(1);
         tint_ff         <= '1;
         dest_x_ff       <= '0;
         dest_y_ff       <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_data[DIM_W-1:0];
            REG_IMAGE_HEIGHT: image_height_ff <= csr_data[DIM_W-1:0];
            REG_FRAME_STEP:   frame_step_ff   <= csr_data[DIM_W-1:0];
            REG_FRAME_NUMBER: frame_number_ff <= csr_data[NUM_W-1:0];
            REG_SCALE:        scale_ff        <= csr_data[SCALE_W-1:0];
            REG_TINT:         tint_ff         <= csr_data;
            REG_DEST_X:       dest_x_ff       <= csr_data[15:0];
            REG_DEST_Y:       dest_y_ff       <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // remainder trial step and room left right of the offset
   assign trial = {rem_ff, prod_ff[DIV_BITS-1]};
   assign room  = img_w - DIM_W'(rem_ff);

   // window unit: product, bit-serial remainder, then window update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         window_offset_ff <= '0;
         window_width_ff  <= DIM_W'(1);
      end else if (csr_write_en) begin
         state_ff <= ST_LOAD;
      end else begin
         unique case (state_ff)
            ST_IDLE: ;
            ST_LOAD: begin
               prod_ff    <= DIV_BITS'(frame_step_ff) * DIV_BITS'(frame_number_ff);
               rem_ff     <= '0;
               div_cnt_ff <= DIV_CNT_W'(DIV_BITS - 1);
               state_ff   <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (trial >= img_w) begin
                  rem_ff <= CNT_W'(trial - img_w);
               end else begin
                  rem_ff <= trial[CNT_W-1:0];
               end
               prod_ff <= prod_ff << 1;
               if (div_cnt_ff == '0) begin
                  state_ff <= ST_FINISH;
               end else begin
                  div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
               end
            end
            ST_FINISH: begin
               if (frame_step_ff == '0) begin
                  window_offset_ff <= '0;
                  window_width_ff  <= img_w;
               end else begin
                  window_offset_ff <= rem_ff;
                  window_width_ff  <= (frame_step_ff < room) ? frame_step_ff : room;
               end
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // handshake
   assign busy       = (state_ff != ST_IDLE);
   assign s2_ready   = !s2_valid_ff || !rsp_stall;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_stall  = csr_write_en || busy || !s1_ready;
   assign req_accept = req_valid && !req_stall;

   // window test on the current counters
   assign col_ext   = DIM_W'(col_ff);
   assign row_ext   = DIM_W'(row_ff);
   assign off_ext   = DIM_W'(window_offset_ff);
   assign win_end   = off_ext + window_width_ff - DIM_W'(1);
   assign in_window = (col_ff >= window_offset_ff) &&
                      ((col_ext - off_ext) < window_width_ff);
   assign last_in   = (row_ext == img_h - DIM_W'(1)) && (col_ext == win_end);
   assign x_in      = col_ff - window_offset_ff;
   assign y_in      = CNT_W'(img_h - DIM_W'(1) - row_ext);
   assign col_wrap  = (col_ext + DIM_W'(1) >= img_w);
   assign row_wrap  = (row_ext + DIM_W'(1) >= img_h);

   // column and row counters
   always_ff @(posedge clock) begin
      if (reset || csr_write_en) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         if (col_wrap) begin
            col_ff <= '0;
            row_ff <= row_wrap ? '0 : row_ff + CNT_W'(1);
         end else begin
            col_ff <= col_ff + CNT_W'(1);
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_accept && in_window;
      end
      if (s1_ready && req_accept) begin
         s1_pixel_ff <= '{r: req_pixel_r, g: req_pixel_g, b: req_pixel_b, a: req_pixel_a};
         s1_x_ff     <= x_in;
         s1_y_ff     <= y_in;
         s1_last_ff  <= last_in;
      end
   end

   // rectangle geometry, all coordinates wrap to 20 bits
   assign scale_eff  = (scale_ff == '0) ? SCALE_W'(1) : scale_ff;
   assign scale_ext  = COORD_W'(scale_eff);
   assign xs         = COORD_W'(s1_x_ff) * scale_ext;
   assign ys         = COORD_W'(s1_y_ff) * scale_ext;
   assign dest_x_ext = {{(COORD_W-16){dest_x_ff[15]}}, dest_x_ff};
   assign dest_y_ext = {{(COORD_W-16){dest_y_ff[15]}}, dest_y_ff};
   assign x0         = dest_x_ext + xs;
   assign bottom     = dest_y_ext + ys;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_ready && s1_valid_ff) begin
         rsp_rect_x0   <= x0;
         rsp_rect_x1   <= x0 + scale_ext - COORD_W'(1);
         rsp_rect_y0   <= COORD_W'(SCREEN_HEIGHT) - bottom - scale_ext;
         rsp_rect_y1   <= COORD_W'(SCREEN_HEIGHT) - COORD_W'(1) - bottom;
         rsp_out_r     <= modulate(s1_pixel_ff.r, tint_ff[31:24]);
         rsp_out_g     <= modulate(s1_pixel_ff.g, tint_ff[23:16]);
         rsp_out_b     <= modulate(s1_pixel_ff.b, tint_ff[15:8]);
         rsp_out_a     <= modulate(s1_pixel_ff.a, tint_ff[7:0]);
         rsp_last_rect <= s1_last_ff;
      end
   end

   assign rsp_valid = s2_valid_ff;

   // no request is taken while the window is being worked out
   a_busy_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      busy |-> req_stall)
      else $error("request accepted during window computation");

   // a settled window lies inside the sheet
   a_window_in_sheet: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (off_ext + window_width_ff <= img_w) && (window_width_ff != '0))
      else $error("frame window outside the sheet");

   // counters stay inside the sheet once the registers have settled
   a_counters_in_sheet: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (col_ext < img_w) && (row_ext < img_h))
      else $error("pixel counters outside the sheet");

endmodule

`default_nettype wire
